// ----- hw/rtl/edf_pkg.sv -----
// Shared types and command codes for the EDF task scheduler.
package edf_pkg;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam int CFG_TASK_COUNT = 0;

    typedef struct packed {
        logic load;
        logic release_en;
        logic exec;
        logic active;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/edf_task_if.sv -----
// Input channel carrying scheduler commands and task data.
interface edf_task_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  task_index;
    logic [15:0] arrival;
    logic [15:0] exec_time;
    logic [15:0] rel_deadline;

    modport source (output valid, cmd, task_index, arrival, exec_time, rel_deadline,
                    input ready);
    modport sink (input valid, cmd, task_index, arrival, exec_time, rel_deadline,
                  output ready);
endinterface

// ----- hw/rtl/edf_result_if.sv -----
// Output channel carrying one scheduler result per command.
interface edf_result_if;
    logic        valid;
    logic        ready;
    logic        running_valid;
    logic [2:0]  running_task;
    logic        task_finished;
    logic [15:0] current_time;
    logic [15:0] stat_waiting;
    logic [16:0] stat_turnaround;

    modport source (output valid, running_valid, running_task, task_finished,
                    current_time, stat_waiting, stat_turnaround,
                    input ready);
    modport sink (input valid, running_valid, running_task, task_finished,
                  current_time, stat_waiting, stat_turnaround,
                  output ready);
endinterface

// ----- hw/rtl/edf_cell.sv -----
// One task entry of the scheduler chain with its slot of the deadline scan.
module edf_cell
    import edf_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int IDX_W     = 3,
    parameter int CELL_IDX  = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [TIME_BITS-1:0] t,
    input  logic [TIME_BITS-1:0] ld_arrival,
    input  logic [TIME_BITS-1:0] ld_exec,
    input  logic [TIME_BITS-1:0] ld_rel,
    input  logic                 win_found,
    input  logic [IDX_W-1:0]     win_idx,
    input  logic                 tin_found,
    input  logic [TIME_BITS:0]   tin_dl,
    input  logic [IDX_W-1:0]     tin_idx,
    output logic                 tout_found,
    output logic [TIME_BITS:0]   tout_dl,
    output logic [IDX_W-1:0]     tout_idx,
    output logic                 fin,
    output logic [TIME_BITS-1:0] waiting,
    output logic [TIME_BITS:0]   turnaround
);

    logic [TIME_BITS-1:0] arrival_reg, arrival_next;
    logic [TIME_BITS-1:0] exec_reg, exec_next;
    logic [TIME_BITS-1:0] rel_reg, rel_next;
    logic [TIME_BITS-1:0] remaining_reg, remaining_next;
    logic [TIME_BITS:0]   absdl_reg, absdl_next;
    logic [TIME_BITS-1:0] waiting_reg, waiting_next;
    logic [TIME_BITS:0]   turn_reg, turn_next;
    logic                 tok_found_reg, tok_found_next;
    logic [TIME_BITS:0]   tok_dl_reg, tok_dl_next;
    logic [IDX_W-1:0]     tok_idx_reg, tok_idx_next;

    logic ready_task;
    logic is_winner;

    assign ready_task = ctrl.active && (remaining_reg != '0) && (arrival_reg <= t);
    assign is_winner  = win_found && (win_idx == IDX_W'(CELL_IDX));

    // Scan slot: keep the earlier task unless this one has a strictly earlier deadline.
    always_comb
    begin
        tok_found_next = tin_found;
        tok_dl_next    = tin_dl;
        tok_idx_next   = tin_idx;
        if (ready_task && (!tin_found || (absdl_reg < tin_dl)))
        begin
            tok_found_next = 1'b1;
            tok_dl_next    = absdl_reg;
            tok_idx_next   = IDX_W'(CELL_IDX);
        end
    end

    always_comb
    begin
        arrival_next   = arrival_reg;
        exec_next      = exec_reg;
        rel_next       = rel_reg;
        remaining_next = remaining_reg;
        absdl_next     = absdl_reg;
        waiting_next   = waiting_reg;
        turn_next      = turn_reg;
        if (ctrl.load)
        begin
            arrival_next   = ld_arrival;
            exec_next      = ld_exec;
            rel_next       = ld_rel;
            remaining_next = ld_exec;
            absdl_next     = {1'b0, ld_rel};
            waiting_next   = '0;
            turn_next      = '0;
        end
        else if (ctrl.release_en)
        begin
            if (ctrl.active && (arrival_reg == t))
            begin
                remaining_next = exec_reg;
                absdl_next     = {1'b0, t} + {1'b0, rel_reg};
            end
        end
        else if (ctrl.exec)
        begin
            if (is_winner)
            begin
                remaining_next = remaining_reg - 1'b1;
                if (remaining_reg == TIME_BITS'(1))
                begin
                    turn_next = {1'b0, t} + (TIME_BITS+1)'(1) - {1'b0, arrival_reg};
                end
            end
            else if (win_found && ready_task && (waiting_reg != '1))
            begin
                waiting_next = waiting_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrival_reg   <= '0;
            exec_reg      <= '0;
            rel_reg       <= '0;
            remaining_reg <= '0;
            absdl_reg     <= '0;
            waiting_reg   <= '0;
            turn_reg      <= '0;
            tok_found_reg <= 1'b0;
        end
        else
        begin
            arrival_reg   <= arrival_next;
            exec_reg      <= exec_next;
            rel_reg       <= rel_next;
            remaining_reg <= remaining_next;
            absdl_reg     <= absdl_next;
            waiting_reg   <= waiting_next;
            turn_reg      <= turn_next;
            tok_found_reg <= tok_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_dl_reg  <= tok_dl_next;
        tok_idx_reg <= tok_idx_next;
    end

    assign tout_found = tok_found_reg;
    assign tout_dl    = tok_dl_reg;
    assign tout_idx   = tok_idx_reg;
    assign fin        = (remaining_reg == TIME_BITS'(1));
    assign waiting    = waiting_reg;
    assign turnaround = turn_reg;

endmodule

// ----- hw/rtl/edf_task_scheduler_top.sv -----
// Top level of the EDF task scheduler: control sequencer, cell chain and APB register.
//
//   channel   direction  handshake        contents
//   in_ch     sink       valid/ready      cmd, task_index, arrival, exec_time, rel_deadline
//   out_ch    source     valid/ready      running info, current_time, statistics
//   apb       slave      psel/penable     task_count at byte address 0
//
// A load or read command passes the accepting step and the hand-off to the output register;
// a tick passes the accepting step, release, the scan while the deadline token walks the
// chain, execute and the hand-off; the token chain length sets the length of the scan.
// A new command is taken only when the previous one has reached the output register.
// A stalled result holds the sequencer in its last step. Reset clears every task
// entry, the time counter and task_count (to 1) at once; no clearing pass is needed.
module edf_task_scheduler_top
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 8,
    parameter int TIME_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    edf_task_if.sink     in_ch,
    edf_result_if.source out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_RELEASE, ST_SCAN, ST_EXEC, ST_FINISH} state_t;

    state_t               state_reg;
    logic [3:0]           task_count_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;

    logic        pend_run_valid_reg;
    logic [2:0]  pend_run_task_reg;
    logic        pend_fin_reg;
    logic [15:0] pend_time_reg;
    logic [15:0] pend_wait_reg;
    logic [16:0] pend_turn_reg;

    logic        out_valid_reg;
    logic        out_run_valid_reg;
    logic [2:0]  out_run_task_reg;
    logic        out_fin_reg;
    logic [15:0] out_time_reg;
    logic [15:0] out_wait_reg;
    logic [16:0] out_turn_reg;

    logic                 in_accept;
    logic                 out_load;
    logic                 cfg_write;
    logic [TIME_BITS-1:0] ld_arrival, ld_exec, ld_rel;

    logic                 tok_found [MAX_TASKS+1];
    logic [TIME_BITS:0]   tok_dl    [MAX_TASKS+1];
    logic [IDX_W-1:0]     tok_idx   [MAX_TASKS+1];
    logic                 fin_arr   [MAX_TASKS];
    logic [TIME_BITS-1:0] wait_arr  [MAX_TASKS];
    logic [TIME_BITS:0]   turn_arr  [MAX_TASKS];

    logic                 win_found;
    logic [IDX_W-1:0]     win_idx;
    logic                 win_fin;
    logic [TIME_BITS-1:0] rd_wait;
    logic [TIME_BITS:0]   rd_turn;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    // The output register takes the result once its last transfer is done.
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ch.ready);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {28'd0, task_count_reg} : 32'd0;

    assign ld_arrival = TIME_BITS'(in_ch.arrival);
    assign ld_exec    = TIME_BITS'(in_ch.exec_time);
    assign ld_rel     = TIME_BITS'(in_ch.rel_deadline);

    assign tok_found[0] = 1'b0;
    assign tok_dl[0]    = '0;
    assign tok_idx[0]   = '0;

    assign win_found = tok_found[MAX_TASKS];
    assign win_idx   = tok_idx[MAX_TASKS];

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        cell_ctrl_t ctrl;

        always_comb
        begin
            ctrl.load       = in_accept && (in_ch.cmd == CMD_LOAD)
                              && ({29'd0, in_ch.task_index} == 32'(i));
            ctrl.release_en = (state_reg == ST_RELEASE);
            ctrl.exec       = (state_reg == ST_EXEC);
            ctrl.active     = ({28'd0, task_count_reg} > 32'(i));
        end

        edf_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .t          (time_reg),
            .ld_arrival (ld_arrival),
            .ld_exec    (ld_exec),
            .ld_rel     (ld_rel),
            .win_found  (win_found),
            .win_idx    (win_idx),
            .tin_found  (tok_found[i]),
            .tin_dl     (tok_dl[i]),
            .tin_idx    (tok_idx[i]),
            .tout_found (tok_found[i+1]),
            .tout_dl    (tok_dl[i+1]),
            .tout_idx   (tok_idx[i+1]),
            .fin        (fin_arr[i]),
            .waiting    (wait_arr[i]),
            .turnaround (turn_arr[i])
        );
    end

    always_comb
    begin
        win_fin = 1'b0;
        rd_wait = '0;
        rd_turn = '0;
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            if (win_idx == IDX_W'(k))
            begin
                win_fin = fin_arr[k];
            end
            if ({29'd0, in_ch.task_index} == 32'(k))
            begin
                rd_wait = wait_arr[k];
                rd_turn = turn_arr[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            task_count_reg     <= 4'd1;
            time_reg           <= '0;
            scan_cnt_reg       <= '0;
            pend_run_valid_reg <= 1'b0;
            pend_run_task_reg  <= 3'd0;
            pend_fin_reg       <= 1'b0;
            pend_time_reg      <= 16'd0;
            pend_wait_reg      <= 16'd0;
            pend_turn_reg      <= 17'd0;
            out_valid_reg      <= 1'b0;
            out_run_valid_reg  <= 1'b0;
            out_run_task_reg   <= 3'd0;
            out_fin_reg        <= 1'b0;
            out_time_reg       <= 16'd0;
            out_wait_reg       <= 16'd0;
            out_turn_reg       <= 17'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                task_count_reg <= pwdata[3:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        pend_run_valid_reg <= 1'b0;
                        pend_run_task_reg  <= 3'd0;
                        pend_fin_reg       <= 1'b0;
                        pend_time_reg      <= 16'(time_reg);
                        case (in_ch.cmd)
                            CMD_TICK:
                            begin
                                pend_wait_reg <= 16'd0;
                                pend_turn_reg <= 17'd0;
                                state_reg     <= ST_RELEASE;
                            end
                            CMD_READ:
                            begin
                                pend_wait_reg <= 16'(rd_wait);
                                pend_turn_reg <= 17'(rd_turn);
                                state_reg     <= ST_FINISH;
                            end
                            default:
                            begin
                                pend_wait_reg <= 16'd0;
                                pend_turn_reg <= 17'd0;
                                state_reg     <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_RELEASE:
                begin
                    scan_cnt_reg <= '0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == CNT_W'(MAX_TASKS - 1))
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    pend_run_valid_reg <= win_found;
                    pend_run_task_reg  <= win_found ? 3'(win_idx) : 3'd0;
                    pend_fin_reg       <= win_found && win_fin;
                    if (time_reg != '1)
                    begin
                        time_reg <= time_reg + 1'b1;
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_run_valid_reg <= pend_run_valid_reg;
                        out_run_task_reg  <= pend_run_task_reg;
                        out_fin_reg       <= pend_fin_reg;
                        out_time_reg      <= pend_time_reg;
                        out_wait_reg      <= pend_wait_reg;
                        out_turn_reg      <= pend_turn_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.running_valid   = out_run_valid_reg;
    assign out_ch.running_task    = out_run_task_reg;
    assign out_ch.task_finished   = out_fin_reg;
    assign out_ch.current_time    = out_time_reg;
    assign out_ch.stat_waiting    = out_wait_reg;
    assign out_ch.stat_turnaround = out_turn_reg;

    // Every accepted command leaves the idle step on the next cycle.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after an accepted command");

    // Time never runs backwards.
    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg >= $past(time_reg))
        else $error("time counter decreased");

    // Time only moves in the execute step of a tick.
    a_time_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg != $past(time_reg)) |-> ($past(state_reg) == ST_EXEC))
        else $error("time counter changed outside a tick");

    // A completed task is always the one reported as running.
    a_fin_has_runner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && pend_fin_reg) |-> pend_run_valid_reg)
        else $error("task completion without a running task");

endmodule

// ----- tb/sv/edf_sched_check_pkg.sv -----
// Expected-result tracking for the EDF scheduler testbench: item types and the scoreboard class.
`timescale 1ns / 1ps
package edf_sched_check_pkg;
    import edf_pkg::*;

    // The fourth command code has no function; the block must answer it with the time only.
    localparam logic [1:0]  CMD_NONE    = 2'd3;
    localparam int          N_ENTRIES   = 8;
    localparam logic [15:0] TIME_MAX    = 16'hFFFF;
    localparam int          PRINT_LIMIT = 40;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  task_index;
        logic [15:0] arrival;
        logic [15:0] exec_time;
        logic [15:0] rel_deadline;
    } sched_cmd_t;

    typedef struct packed {
        logic        running_valid;
        logic [2:0]  running_task;
        logic        task_finished;
        logic [15:0] current_time;
        logic [15:0] stat_waiting;
        logic [16:0] stat_turnaround;
    } sched_result_t;

    class edf_schedule_checker;
        logic [3:0]    task_count;
        logic [15:0]   arr_time [N_ENTRIES];
        logic [15:0]   exec_len [N_ENTRIES];
        logic [15:0]   rel_dl   [N_ENTRIES];
        logic [15:0]   remain   [N_ENTRIES];
        logic [16:0]   abs_dl   [N_ENTRIES];
        logic [15:0]   wait_cnt [N_ENTRIES];
        logic [16:0]   turn_cnt [N_ENTRIES];
        logic [15:0]   now;
        sched_result_t expected_q [$];
        int unsigned   mismatches;
        int unsigned   accepted;
        int unsigned   checked;
        int unsigned   finishes;

        function new();
            task_count = 4'd1;
            now        = '0;
            mismatches = 0;
            accepted   = 0;
            checked    = 0;
            finishes   = 0;
            foreach (arr_time[i])
            begin
                arr_time[i] = '0;
                exec_len[i] = '0;
                rel_dl[i]   = '0;
                remain[i]   = '0;
                abs_dl[i]   = '0;
                wait_cnt[i] = '0;
                turn_cnt[i] = '0;
            end
        endfunction

        function void set_task_count(logic [3:0] value);
            task_count = value;
        endfunction

        // Updates the schedule state for one accepted command and queues its outcome.
        function void note_command(sched_cmd_t c);
            sched_result_t r;
            int            n;
            bit            found;
            logic [2:0]    pick;
            r     = '0;
            found = 1'b0;
            pick  = '0;
            n     = (task_count > 4'd8) ? N_ENTRIES : int'(task_count);
            r.current_time = now;
            accepted++;
            case (c.cmd)
                CMD_LOAD:
                begin
                    arr_time[c.task_index] = c.arrival;
                    exec_len[c.task_index] = c.exec_time;
                    rel_dl[c.task_index]   = c.rel_deadline;
                    remain[c.task_index]   = c.exec_time;
                    abs_dl[c.task_index]   = {1'b0, c.rel_deadline};
                    wait_cnt[c.task_index] = '0;
                    turn_cnt[c.task_index] = '0;
                end
                CMD_TICK:
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (arr_time[i] == now)
                        begin
                            remain[i] = exec_len[i];
                            abs_dl[i] = {1'b0, now} + {1'b0, rel_dl[i]};
                        end
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        if (remain[i] != 0 && arr_time[i] <= now)
                        begin
                            if (!found || abs_dl[i] < abs_dl[pick])
                            begin
                                found = 1'b1;
                                pick  = 3'(i);
                            end
                        end
                    end
                    if (found)
                    begin
                        remain[pick] = remain[pick] - 16'd1;
                        for (int i = 0; i < n; i++)
                        begin
                            if (i != pick && remain[i] != 0 && arr_time[i] <= now &&
                                wait_cnt[i] != TIME_MAX)
                                wait_cnt[i] = wait_cnt[i] + 16'd1;
                        end
                        r.running_valid = 1'b1;
                        r.running_task  = pick;
                        if (remain[pick] == 0)
                        begin
                            turn_cnt[pick]  = {1'b0, now} + 17'd1 - {1'b0, arr_time[pick]};
                            r.task_finished = 1'b1;
                        end
                    end
                    if (now != TIME_MAX)
                        now = now + 16'd1;
                end
                CMD_READ:
                begin
                    r.stat_waiting    = wait_cnt[c.task_index];
                    r.stat_turnaround = turn_cnt[c.task_index];
                end
                default:
                begin
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.task_finished === 1'b1)
                finishes++;
            field_check("running_valid",   want.running_valid,   got.running_valid);
            field_check("running_task",    want.running_task,    got.running_task);
            field_check("task_finished",   want.task_finished,   got.task_finished);
            field_check("current_time",    want.current_time,    got.current_time);
            field_check("stat_waiting",    want.stat_waiting,    got.stat_waiting);
            field_check("stat_turnaround", want.stat_turnaround, got.stat_turnaround);
        endfunction

        function int unsigned pending_count();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_edf_task_scheduler_top.sv -----
// Top-level testbench for the EDF task scheduler: stimulus, handshakes and the final verdict.
`timescale 1ns / 1ps
module tb_edf_task_scheduler_top;
    import edf_pkg::*;
    import edf_sched_check_pkg::*;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [2:0]  TASK_COUNT_ADDR = 3'(CFG_TASK_COUNT * 4);

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold_req;
    int          hold_left;
    int unsigned cycle_count;

    edf_task_if   task_ch ();
    edf_result_if result_ch ();

    edf_schedule_checker sb = new();

    edf_task_scheduler_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (task_ch),
        .out_ch  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, sb.pending_count());
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: checks every transfer and applies random or long stalls.
    initial
    begin
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result('{running_valid:   result_ch.running_valid,
                                  running_task:    result_ch.running_task,
                                  task_finished:   result_ch.task_finished,
                                  current_time:    result_ch.current_time,
                                  stat_waiting:    result_ch.stat_waiting,
                                  stat_turnaround: result_ch.stat_turnaround});
            if (recv_hold_req)
            begin
                hold_left     = HOLD_CYCLES;
                recv_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic sched_cmd_t mk_cmd(logic [1:0] cmd, logic [2:0] idx, logic [15:0] arr,
                                          logic [15:0] ex, logic [15:0] rel);
        sched_cmd_t c;
        c.cmd          = cmd;
        c.task_index   = idx;
        c.arrival      = arr;
        c.exec_time    = ex;
        c.rel_deadline = rel;
        return c;
    endfunction

    // Offers one command and returns in the cycle of its transfer.
    task automatic send_cmd(input sched_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            task_ch.valid <= 1'b0;
            @(posedge clk);
        end
        task_ch.valid        <= 1'b1;
        task_ch.cmd          <= c.cmd;
        task_ch.task_index   <= c.task_index;
        task_ch.arrival      <= c.arrival;
        task_ch.exec_time    <= c.exec_time;
        task_ch.rel_deadline <= c.rel_deadline;
        do
            @(posedge clk);
        while (!task_ch.ready);
        sb.note_command(c);
    endtask

    task automatic tick();
        send_cmd(mk_cmd(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    task automatic read_stats(input logic [2:0] idx);
        send_cmd(mk_cmd(CMD_READ, idx, 16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    // Stops offering and waits until every queued result has been taken.
    task automatic drain_results();
        task_ch.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_task_count(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TASK_COUNT_ADDR;
        pwdata  <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_task_count(value);
    endtask

    // Each set loads a fresh task table around the current time and then mostly ticks it.
    task automatic run_random_phase(input int unsigned quota);
        int unsigned start;
        int          pick;
        int          n;
        logic [3:0]  cnt;
        logic [15:0] arr;
        start = sb.accepted;
        while (sb.accepted - start < quota)
        begin
            drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                cnt = 4'd0;
            else if (pick < 12)
                cnt = 4'($urandom_range(9, 15));
            else if (pick < 30)
                cnt = 4'd8;
            else
                cnt = 4'($urandom_range(1, 8));
            write_task_count(cnt);
            n = (cnt > 4'd8) ? 8 : int'(cnt);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0 && sb.now >= 16'd3)
                    arr = sb.now - 16'($urandom_range(0, 3));
                else
                    arr = sb.now + 16'($urandom_range(0, 12));
                send_cmd(mk_cmd(CMD_LOAD, 3'(i), arr, 16'($urandom_range(0, 6)),
                                16'($urandom_range(0, 40))));
            end
            repeat ($urandom_range(14, 26))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    tick();
                else if (pick < 85)
                    read_stats(3'($urandom));
                else if (pick < 90)
                    send_cmd(mk_cmd(CMD_NONE, 3'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom)));
                else
                    send_cmd(mk_cmd(CMD_LOAD, 3'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom)));
            end
        end
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        task_ch.valid        <= 1'b0;
        task_ch.cmd          <= CMD_LOAD;
        task_ch.task_index   <= '0;
        task_ch.arrival      <= '0;
        task_ch.exec_time    <= '0;
        task_ch.rel_deadline <= '0;
        recv_hold_req = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 65;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, unused code and extreme fields with a single entry.
        write_task_count(4'd1);
        tick();
        read_stats(3'd0);
        send_cmd(mk_cmd(CMD_NONE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_cmd(mk_cmd(CMD_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        read_stats(3'd7);
        send_cmd(mk_cmd(CMD_LOAD, 3'd0, sb.now, 16'd2, 16'd3));
        tick();
        tick();
        read_stats(3'd0);

        // No entry takes part, so the loaded task must stay untouched.
        drain_results();
        write_task_count(4'd0);
        send_cmd(mk_cmd(CMD_LOAD, 3'd0, sb.now, 16'd3, 16'd30));
        tick();
        read_stats(3'd0);

        // A count above the table acts as the full table: ties, zero work, late arrival.
        drain_results();
        write_task_count(4'd15);
        send_cmd(mk_cmd(CMD_LOAD, 3'd1, sb.now, 16'd2, 16'd10));
        send_cmd(mk_cmd(CMD_LOAD, 3'd2, sb.now, 16'd2, 16'd10));
        send_cmd(mk_cmd(CMD_LOAD, 3'd3, sb.now, 16'd0, 16'd0));
        send_cmd(mk_cmd(CMD_LOAD, 3'd4, sb.now + 16'd3, 16'd1, 16'd0));
        repeat (7) tick();
        read_stats(3'd0);
        read_stats(3'd2);
        read_stats(3'd4);

        run_random_phase(270);
        drain_results();
        send_idle_pct = 65;
        recv_idle_pct = 18;
        run_random_phase(270);

        // No idling from here on; one long receiver stall fills the block first.
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_req = 1'b1;
        run_random_phase(260);

        drain_results();
        repeat (20) @(posedge clk);
        $display("Run covered %0d commands and %0d checked results, %0d task completions,",
                 sb.accepted, sb.checked, sb.finishes);
        $display("task counts 0 to 15, deadline ties, late arrivals and stalls on both sides.");
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
